/* hw/rtl/ssc_pkg.sv */
`default_nettype none
package ssc_pkg;

	localparam int SIG_W = 16;
	localparam int ADC_W = 12;
	localparam int THR_W = 8;
	localparam int CHN_W = 11;
	localparam int IDX_W = 10;
	localparam int CNT_W = 9;
	localparam int REG_W = 12;
	localparam int RIX_W = 2;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_FETCH = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef enum logic [RIX_W-1:0] {
		REG_SEED_THR = 2'd0,
		REG_HIT_THR  = 2'd1,
		REG_MAX_ADC  = 2'd2,
		REG_CHANNELS = 2'd3
	} reg_index_t;

	localparam logic [THR_W-1:0] SEED_THR_RST = 8'd5;
	localparam logic [THR_W-1:0] HIT_THR_RST  = 8'd3;
	localparam logic [ADC_W-1:0] MAX_ADC_RST  = 12'd255;
	localparam logic [CHN_W-1:0] CHANNELS_RST = 11'd256;

	// scan pointer value taken when a cluster closes
	typedef enum logic [1:0] {
		CL_SEED_NEXT,
		CL_WALK,
		CL_WALK_NEXT
	} close_sel_t;

	typedef struct packed {
		logic       start;
		logic       load;
		logic       rd_walk;
		logic       scan_inc;
		logic       seed_take;
		logic       walk_dec;
		logic       walk_inc;
		logic       walk_seed1;
		logic       close;
		close_sel_t close_sel;
		logic       scan_clamp;
		logic       emit_member;
		logic       emit_done;
		logic       emit_down;
		logic       emit_edge;
		logic       emit_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
		logic scan_ge_ch;
		logic walk_ge_ch;
		logic walk_zero;
		logic seed_last;
		logic walk_last;
		logic seed_pass;
		logic hit_pass;
	} dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/ssc_strip_if.sv */
`default_nettype none
interface ssc_strip_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         command;
	logic signed [ssc_pkg::SIG_W-1:0]   strip_signal;
	logic signed [ssc_pkg::SIG_W-1:0]   strip_snr;
	logic [ssc_pkg::ADC_W-1:0]          adc_value;
	logic                               noise_zero;
	logic                               screened_in;

	modport source (output valid, command, strip_signal, strip_snr, adc_value,
		noise_zero, screened_in, input ready);
	modport sink (input valid, command, strip_signal, strip_snr, adc_value,
		noise_zero, screened_in, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ssc_member_if.sv */
`default_nettype none
interface ssc_member_if;
	logic                               valid;
	logic                               ready;
	logic [ssc_pkg::IDX_W-1:0]          strip_index;
	logic signed [ssc_pkg::SIG_W-1:0]   member_signal;
	logic signed [ssc_pkg::SIG_W-1:0]   member_snr;
	logic [ssc_pkg::ADC_W-1:0]          member_adc;
	logic                               saturated;
	logic                               member_screened;
	logic                               edge_strip;
	logic [ssc_pkg::CNT_W-1:0]          cluster_number;
	logic                               last_in_cluster;
	logic                               frame_done;

	modport source (output valid, strip_index, member_signal, member_snr, member_adc,
		saturated, member_screened, edge_strip, cluster_number, last_in_cluster,
		frame_done, input ready);
	modport sink (input valid, strip_index, member_signal, member_snr, member_adc,
		saturated, member_screened, edge_strip, cluster_number, last_in_cluster,
		frame_done, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ssc_cfg_if.sv */
`default_nettype none
interface ssc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ssc_pkg::RIX_W-1:0]     index;
	logic [ssc_pkg::REG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ssc_datapath.sv */
`default_nettype none
module ssc_datapath #(
	parameter int MAX_STRIPS = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ssc_pkg::ctrl_cmd_t               cmd,
	output ssc_pkg::dp_status_t                   status,
	input  wire logic                             cfg_we,
	input  wire logic [ssc_pkg::RIX_W-1:0]        cfg_index,
	input  wire logic [ssc_pkg::REG_W-1:0]        cfg_data,
	input  wire logic signed [ssc_pkg::SIG_W-1:0] strip_signal,
	input  wire logic signed [ssc_pkg::SIG_W-1:0] strip_snr,
	input  wire logic [ssc_pkg::ADC_W-1:0]        adc_value,
	input  wire logic                             noise_zero,
	input  wire logic                             screened_in,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [ssc_pkg::IDX_W-1:0]             strip_index,
	output logic signed [ssc_pkg::SIG_W-1:0]      member_signal,
	output logic signed [ssc_pkg::SIG_W-1:0]      member_snr,
	output logic [ssc_pkg::ADC_W-1:0]             member_adc,
	output logic                                  saturated,
	output logic                                  member_screened,
	output logic                                  edge_strip,
	output logic [ssc_pkg::CNT_W-1:0]             cluster_number,
	output logic                                  last_in_cluster,
	output logic                                  frame_done
);
	import ssc_pkg::*;

	localparam int AW = $clog2(MAX_STRIPS);
	localparam int PW = (AW + 1 > CHN_W) ? AW + 1 : CHN_W;
	localparam int EW = 2 * SIG_W + ADC_W + 2;
	localparam logic [PW-1:0] MAX_P = PW'(MAX_STRIPS);

	logic [THR_W-1:0] seed_thr_q, hit_thr_q;
	logic [ADC_W-1:0] max_adc_q;
	logic [CHN_W-1:0] channels_q;

	logic [PW-1:0] load_ptr_q, scan_ptr_q, walk_ptr_q, seed_pos_q;
	logic [CNT_W-1:0] count_q;

	logic [EW-1:0] store_q [MAX_STRIPS];
	logic [EW-1:0] rd_q;
	logic [PW-1:0] rd_ptr;

	logic [PW-1:0] ch;
	logic signed [SIG_W-1:0] rd_sig, rd_snr;
	logic [ADC_W-1:0] rd_adc;
	logic rd_nz, rd_scr;
	logic signed [SIG_W:0] snr_x, seed_lim, hit_lim;
	logic [PW-1:0] close_val;

	assign ch = ({{(PW-CHN_W){1'b0}}, channels_q} > MAX_P) ? MAX_P
		: {{(PW-CHN_W){1'b0}}, channels_q};
	assign rd_ptr = cmd.rd_walk ? walk_ptr_q : scan_ptr_q;
	assign {rd_sig, rd_snr, rd_adc, rd_nz, rd_scr} = rd_q;

	// thresholds are integer sigmas against the Q8.8 value
	assign snr_x = {rd_snr[SIG_W-1], rd_snr};
	assign seed_lim = {1'b0, seed_thr_q, 8'h00};
	assign hit_lim = {1'b0, hit_thr_q, 8'h00};

	assign status.out_busy = out_valid && !out_ready;
	assign status.scan_ge_ch = scan_ptr_q >= ch;
	assign status.walk_ge_ch = walk_ptr_q >= ch;
	assign status.walk_zero = walk_ptr_q == '0;
	assign status.seed_last = (seed_pos_q + PW'(1)) >= ch;
	assign status.walk_last = (walk_ptr_q + PW'(1)) >= ch;
	assign status.seed_pass = !rd_nz && (snr_x > seed_lim);
	assign status.hit_pass = !rd_nz && (snr_x > hit_lim);

	always_comb begin
		unique case (cmd.close_sel)
			CL_SEED_NEXT: close_val = seed_pos_q + PW'(1);
			CL_WALK:      close_val = walk_ptr_q;
			CL_WALK_NEXT: close_val = walk_ptr_q + PW'(1);
			default:      close_val = walk_ptr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load && load_ptr_q < MAX_P) begin
			store_q[load_ptr_q[AW-1:0]] <= {strip_signal, strip_snr, adc_value,
				noise_zero, screened_in};
		end
		rd_q <= store_q[rd_ptr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_thr_q <= SEED_THR_RST;
			hit_thr_q <= HIT_THR_RST;
			max_adc_q <= MAX_ADC_RST;
			channels_q <= CHANNELS_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SEED_THR: seed_thr_q <= cfg_data[THR_W-1:0];
				REG_HIT_THR:  hit_thr_q <= cfg_data[THR_W-1:0];
				REG_MAX_ADC:  max_adc_q <= cfg_data[ADC_W-1:0];
				REG_CHANNELS: channels_q <= cfg_data[CHN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			scan_ptr_q <= '0;
			walk_ptr_q <= '0;
			seed_pos_q <= '0;
			count_q <= '0;
		end else if (cmd.start) begin
			load_ptr_q <= '0;
			scan_ptr_q <= '0;
			walk_ptr_q <= '0;
			seed_pos_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.load && load_ptr_q < MAX_P)
				load_ptr_q <= load_ptr_q + PW'(1);
			if (cmd.scan_inc)
				scan_ptr_q <= scan_ptr_q + PW'(1);
			if (cmd.scan_clamp && scan_ptr_q > ch)
				scan_ptr_q <= ch;
			if (cmd.seed_take) begin
				seed_pos_q <= scan_ptr_q;
				walk_ptr_q <= scan_ptr_q;
			end
			if (cmd.walk_dec)
				walk_ptr_q <= walk_ptr_q - PW'(1);
			if (cmd.walk_inc)
				walk_ptr_q <= walk_ptr_q + PW'(1);
			if (cmd.walk_seed1)
				walk_ptr_q <= seed_pos_q + PW'(1);
			if (cmd.close) begin
				scan_ptr_q <= close_val;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_member || cmd.emit_done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_done) begin
			strip_index <= '0;
			member_signal <= '0;
			member_snr <= '0;
			member_adc <= '0;
			saturated <= 1'b0;
			member_screened <= 1'b0;
			edge_strip <= 1'b0;
			cluster_number <= '0;
			last_in_cluster <= 1'b0;
			frame_done <= 1'b1;
		end else if (cmd.emit_member) begin
			strip_index <= walk_ptr_q[IDX_W-1:0];
			member_signal <= rd_sig;
			member_snr <= rd_snr;
			member_adc <= rd_adc;
			saturated <= rd_adc >= max_adc_q;
			member_screened <= rd_scr || (cmd.emit_down && rd_adc == max_adc_q);
			edge_strip <= cmd.emit_edge;
			cluster_number <= count_q;
			last_in_cluster <= cmd.emit_last;
			frame_done <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_member || cmd.emit_done) |-> !(out_valid && !out_ready))
		else $error("result word overwritten while held");
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_ptr_q <= MAX_P)
		else $error("load pointer past store depth");
	a_walk_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_dec |-> walk_ptr_q != '0)
		else $error("downward walk below strip 0");

endmodule
`default_nettype wire

/* hw/rtl/ssc_ctrl.sv */
`default_nettype none
module ssc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         command,
	input  wire ssc_pkg::dp_status_t status,
	output ssc_pkg::ctrl_cmd_t      cmd
);
	import ssc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_EVAL
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DOWN,
		PH_UP
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic accept;
	logic end_down;

	assign in_ready = state_q == S_IDLE;
	assign accept = in_valid && in_ready;
	assign end_down = !status.hit_pass || status.walk_zero;

	always_comb begin
		cmd = '0;
		cmd.close_sel = CL_WALK;
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_code_t'(command))
						CMD_START: begin
							cmd.start = 1'b1;
							phase_d = PH_IDLE;
						end
						CMD_LOAD:  cmd.load = 1'b1;
						CMD_FETCH: state_d = S_LOOK;
						default: ;
					endcase
				end
			end
			S_LOOK: begin
				unique case (phase_q)
					PH_DOWN: begin
						cmd.rd_walk = 1'b1;
						state_d = S_EVAL;
					end
					PH_UP: begin
						if (status.walk_ge_ch) begin
							// count lowered under an open cluster
							cmd.close = 1'b1;
							cmd.close_sel = CL_WALK;
							phase_d = PH_IDLE;
						end else begin
							cmd.rd_walk = 1'b1;
							state_d = S_EVAL;
						end
					end
					default: begin
						if (status.scan_ge_ch) begin
							if (!status.out_busy) begin
								cmd.emit_done = 1'b1;
								cmd.scan_clamp = 1'b1;
								state_d = S_IDLE;
							end
						end else begin
							state_d = S_EVAL;
						end
					end
				endcase
			end
			S_EVAL: begin
				unique case (phase_q)
					PH_DOWN: begin
						// keep the walk strip in the read register while stalled
						cmd.rd_walk = 1'b1;
						if (!status.out_busy) begin
							cmd.emit_member = 1'b1;
							cmd.emit_down = 1'b1;
							cmd.emit_edge = !status.hit_pass;
							cmd.emit_last = end_down && status.seed_last;
							state_d = S_IDLE;
							if (!end_down) begin
								cmd.walk_dec = 1'b1;
							end else if (status.seed_last) begin
								cmd.close = 1'b1;
								cmd.close_sel = CL_SEED_NEXT;
								phase_d = PH_IDLE;
							end else begin
								cmd.walk_seed1 = 1'b1;
								phase_d = PH_UP;
							end
						end
					end
					PH_UP: begin
						cmd.rd_walk = 1'b1;
						if (!status.out_busy) begin
							cmd.emit_member = 1'b1;
							cmd.emit_edge = !status.hit_pass;
							cmd.emit_last = !status.hit_pass || status.walk_last;
							state_d = S_IDLE;
							if (!status.hit_pass || status.walk_last) begin
								cmd.close = 1'b1;
								cmd.close_sel = CL_WALK_NEXT;
								phase_d = PH_IDLE;
							end else begin
								cmd.walk_inc = 1'b1;
							end
						end
					end
					default: begin
						state_d = S_LOOK;
						if (status.seed_pass) begin
							cmd.seed_take = 1'b1;
							phase_d = PH_DOWN;
						end else begin
							cmd.scan_inc = 1'b1;
						end
					end
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	a_one_walk_step: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.walk_dec, cmd.walk_inc, cmd.walk_seed1, cmd.seed_take}) <= 1)
		else $error("conflicting walk pointer updates");
	a_emit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_member || cmd.emit_done) |=> state_q == S_IDLE)
		else $error("fetch did not finish after its result");
	a_scan_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && phase_q == PH_IDLE) |-> !cmd.emit_member)
		else $error("member emitted during seed scan");

endmodule
`default_nettype wire

/* hw/rtl/strip_seed_hit_clustering.sv */
// Seed-and-neighbour clustering over one strip plane. A start word opens a frame, load words
// fill the strip store in ascending order, and each fetch word returns one cluster member:
// seed, the downward walk with its failing edge strip, then the upward walk with its edge
// strip, or a frame_done word once no seed is left. A fetch that continues a cluster goes
// through decide, store read and result steps, and a fetch that must find a new seed also
// takes a store read and a test for each strip scanned, since each strip goes through the
// single registered read port of the store. The store is not cleared by reset; the user must
// keep fetches to strips loaded since reset, as the block itself does not enforce it.
`default_nettype none
module strip_seed_hit_clustering #(
	parameter int MAX_STRIPS = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ssc_cfg_if.sink     cfg,
	ssc_strip_if.sink   strip_in,
	ssc_member_if.source member_out
);
	import ssc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	ssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (strip_in.valid),
		.in_ready (strip_in.ready),
		.command  (strip_in.command),
		.status   (status),
		.cmd      (cmd)
	);

	ssc_datapath #(
		.MAX_STRIPS (MAX_STRIPS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.strip_signal    (strip_in.strip_signal),
		.strip_snr       (strip_in.strip_snr),
		.adc_value       (strip_in.adc_value),
		.noise_zero      (strip_in.noise_zero),
		.screened_in     (strip_in.screened_in),
		.out_valid       (member_out.valid),
		.out_ready       (member_out.ready),
		.strip_index     (member_out.strip_index),
		.member_signal   (member_out.member_signal),
		.member_snr      (member_out.member_snr),
		.member_adc      (member_out.member_adc),
		.saturated       (member_out.saturated),
		.member_screened (member_out.member_screened),
		.edge_strip      (member_out.edge_strip),
		.cluster_number  (member_out.cluster_number),
		.last_in_cluster (member_out.last_in_cluster),
		.frame_done      (member_out.frame_done)
	);

endmodule
`default_nettype wire
